// ===== rtl/sdc_pkg.sv =====
package sdc_pkg;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b0000000001,
        PH_POWERUP  = 10'b0000000010,
        PH_NEXT_CMD = 10'b0000000100,
        PH_CMD_BYTE = 10'b0000001000,
        PH_RESP     = 10'b0000010000,
        PH_EXTRA    = 10'b0000100000,
        PH_TOKEN    = 10'b0001000000,
        PH_DATA     = 10'b0010000000,
        PH_WR_DATA  = 10'b0100000000,
        PH_BUSY     = 10'b1000000000
    } phase_t;

    localparam logic [1:0] OP_EXCHANGE = 2'd0;
    localparam logic [1:0] OP_INIT     = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_WRITE    = 2'd3;

    localparam logic [1:0] CFG_ACMD41 = 2'd0;
    localparam logic [1:0] CFG_TOKEN  = 2'd1;
    localparam logic [1:0] CFG_BUSY   = 2'd2;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_NO_CARD = 4'd1;
    localparam logic [3:0] ST_LEGACY  = 4'd2;
    localparam logic [3:0] ST_VOLTAGE = 4'd3;
    localparam logic [3:0] ST_ACMD41  = 4'd4;
    localparam logic [3:0] ST_OCR     = 4'd5;
    localparam logic [3:0] ST_CSD     = 4'd6;
    localparam logic [3:0] ST_WAIT    = 4'd7;
    localparam logic [3:0] ST_CMD16   = 4'd8;
    localparam logic [3:0] ST_READ    = 4'd9;
    localparam logic [3:0] ST_WRITE   = 4'd10;

    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD9  = 6'd9;
    localparam logic [5:0] CMD13 = 6'd13;
    localparam logic [5:0] CMD16 = 6'd16;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD24 = 6'd24;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam int BLOCK_BYTES = 512;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] block_address;
        logic [7:0]  miso_byte;
        logic [7:0]  write_data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  mosi_byte;
        logic        select_card;
        logic [7:0]  read_byte;
        logic        read_byte_valid;
        logic        write_byte_taken;
        logic        done_res;
        logic [3:0]  status;
        logic        high_capacity;
        logic [32:0] card_blocks;
        logic        card_ready;
    } out_item_t;

    function automatic logic [47:0] make_frame(logic [5:0] c, logic [31:0] arg,
                                               logic [7:0] crc);
        make_frame = {2'b01, c, arg, crc};
    endfunction

endpackage

// ===== rtl/sdc_if.sv =====
interface sdc_in_if;
    logic               valid;
    logic               ready;
    sdc_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sdc_out_if;
    logic               valid;
    logic               ready;
    sdc_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sdc_csd_decode.sv =====
module sdc_csd_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 hc,
    input  logic [15:0][7:0]     r,
    output logic [32:0]          blocks
);
    logic [32:0] blocks_reg;
    logic [32:0] blocks_next;
    logic [21:0] cs2;
    logic [11:0] cs1;
    logic [2:0]  mult;
    logic [3:0]  bl;
    logic [4:0]  sh;
    logic [45:0] wide;

    always_comb
    begin
        cs2  = {r[7][5:0], r[8], r[9]};
        bl   = r[5][3:0];
        mult = {r[9][1:0], r[10][7]};
        cs1  = {r[6][1:0], r[7], r[8][7:6]};
        sh   = 5'(mult) + 5'd2 + 5'(bl);
        wide = 46'({34'd0, cs1} + 46'd1) << sh;
        blocks_next = blocks_reg;
        if (load)
        begin
            if (hc)
                blocks_next = (33'(cs2) + 33'd1) << 10;
            else
                blocks_next = wide[41:9];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blocks_reg <= '0;
        else
            blocks_reg <= blocks_next;
    end

    assign blocks = blocks_reg;
endmodule

// ===== rtl/sdc_core.sv =====
module sdc_core #(
    parameter int RESPONSE_POLLS = 10,
    parameter int POWERUP_BYTES  = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sdc_pkg::in_item_t   item,
    input  logic [15:0]         acmd41_limit,
    input  logic [15:0]         token_limit,
    input  logic [15:0]         busy_limit,
    output sdc_pkg::out_item_t  result
);
    sdc_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  cnt_reg, cnt_next;
    logic [15:0] poll_reg, poll_next;
    logic [47:0] frame_reg, frame_next;
    logic [15:0][7:0] regs_reg;
    logic        reg_we;
    logic [3:0]  reg_wa;
    logic        hc_reg, hc_next;
    logic        init_reg, init_next;
    logic        csd_load;
    logic [32:0] blocks;

    logic [7:0]  mosi;
    logic        sel, rdv, taken, done;
    logic [7:0]  rd;
    logic [3:0]  st;
    logic [5:0]  cidx;
    logic [7:0]  miso;
    logic [31:0] taddr;

    sdc_csd_decode u_csd (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (csd_load && step),
        .hc     (hc_reg),
        .r      (regs_reg),
        .blocks (blocks)
    );

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        poll_next  = poll_reg;
        frame_next = frame_reg;
        hc_next    = hc_reg;
        init_next  = init_reg;
        reg_we = 1'b0;
        reg_wa = cnt_reg[3:0];
        csd_load = 1'b0;
        mosi = 8'hFF; sel = 1'b0; rd = 8'd0; rdv = 1'b0; taken = 1'b0;
        done = 1'b0; st = sdc_pkg::ST_OK;
        cidx = frame_reg[45:40];
        miso = item.miso_byte;
        taddr = hc_reg ? item.block_address : {item.block_address[22:0], 9'd0};

        if (item.opcode == sdc_pkg::OP_INIT)
        begin
            init_next = 1'b0; poll_next = '0;
            phase_next = sdc_pkg::PH_POWERUP; cnt_next = 10'd1;
        end
        else if (item.opcode != sdc_pkg::OP_EXCHANGE)
        begin
            frame_next = sdc_pkg::make_frame(
                (item.opcode == sdc_pkg::OP_READ) ? sdc_pkg::CMD17 : sdc_pkg::CMD24,
                taddr, 8'hFF);
            sel = 1'b1; phase_next = sdc_pkg::PH_CMD_BYTE; cnt_next = '0;
        end
        else
        begin
            case (phase_reg)
                sdc_pkg::PH_POWERUP:
                begin
                    if (cnt_reg < 10'(POWERUP_BYTES))
                        cnt_next = cnt_reg + 10'd1;
                    else
                    begin
                        frame_next = sdc_pkg::make_frame(sdc_pkg::CMD0, 32'd0, 8'h95);
                        sel = 1'b1; phase_next = sdc_pkg::PH_CMD_BYTE; cnt_next = '0;
                    end
                end
                sdc_pkg::PH_NEXT_CMD:
                begin
                    sel = 1'b1; phase_next = sdc_pkg::PH_CMD_BYTE; cnt_next = '0;
                end
                sdc_pkg::PH_CMD_BYTE:
                begin
                    sel = 1'b1;
                    if (cnt_reg < 10'd6)
                    begin
                        cnt_next = cnt_reg + 10'd1;
                        case (cnt_reg[2:0])
                            3'd0: mosi = frame_reg[47:40];
                            3'd1: mosi = frame_reg[39:32];
                            3'd2: mosi = frame_reg[31:24];
                            3'd3: mosi = frame_reg[23:16];
                            3'd4: mosi = frame_reg[15:8];
                            default: mosi = frame_reg[7:0];
                        endcase
                    end
                    else
                    begin
                        phase_next = sdc_pkg::PH_RESP; cnt_next = 10'd1;
                    end
                end
                sdc_pkg::PH_RESP:
                begin
                    if (miso[7] && cnt_reg < 10'(RESPONSE_POLLS))
                    begin
                        cnt_next = cnt_reg + 10'd1; sel = 1'b1;
                    end
                    else
                    begin
                        case (cidx)
                            sdc_pkg::CMD0:
                            begin
                                if (miso != 8'h01)
                                begin
                                    done = 1'b1; st = sdc_pkg::ST_NO_CARD;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    frame_next = sdc_pkg::make_frame(sdc_pkg::CMD8,
                                                                     32'h1AA, 8'h87);
                                    phase_next = sdc_pkg::PH_NEXT_CMD;
                                end
                            end
                            sdc_pkg::CMD8:
                            begin
                                if (miso != 8'h01)
                                begin
                                    done = 1'b1; st = sdc_pkg::ST_LEGACY;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    frame_next[7:0] = miso; sel = 1'b1;
                                    phase_next = sdc_pkg::PH_EXTRA; cnt_next = '0;
                                end
                            end
                            sdc_pkg::CMD55:
                            begin
                                frame_next = sdc_pkg::make_frame(sdc_pkg::CMD41,
                                                                 32'h40000000, 8'h01);
                                phase_next = sdc_pkg::PH_NEXT_CMD;
                            end
                            sdc_pkg::CMD41:
                            begin
                                if (miso == 8'h00)
                                begin
                                    frame_next = sdc_pkg::make_frame(sdc_pkg::CMD58,
                                                                     32'd0, 8'hFD);
                                    phase_next = sdc_pkg::PH_NEXT_CMD;
                                end
                                else if (poll_reg >= acmd41_limit)
                                begin
                                    done = 1'b1; st = sdc_pkg::ST_ACMD41;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    poll_next = poll_reg + 16'd1;
                                    frame_next = sdc_pkg::make_frame(sdc_pkg::CMD55,
                                                                     32'd0, 8'h01);
                                    phase_next = sdc_pkg::PH_NEXT_CMD;
                                end
                            end
                            sdc_pkg::CMD58, sdc_pkg::CMD13:
                            begin
                                frame_next[7:0] = miso; sel = 1'b1;
                                phase_next = sdc_pkg::PH_EXTRA; cnt_next = '0;
                            end
                            sdc_pkg::CMD9, sdc_pkg::CMD17:
                            begin
                                if (miso != 8'h00)
                                begin
                                    done = 1'b1;
                                    st = (cidx == sdc_pkg::CMD9) ? sdc_pkg::ST_CSD
                                                                 : sdc_pkg::ST_READ;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else if (token_limit == 16'd0)
                                begin
                                    done = 1'b1; st = sdc_pkg::ST_WAIT;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    sel = 1'b1; phase_next = sdc_pkg::PH_TOKEN;
                                    poll_next = 16'd1;
                                end
                            end
                            sdc_pkg::CMD16:
                            begin
                                done = 1'b1; phase_next = sdc_pkg::PH_IDLE;
                                if (miso != 8'h00)
                                    st = sdc_pkg::ST_CMD16;
                                else
                                    init_next = 1'b1;
                            end
                            sdc_pkg::CMD24:
                            begin
                                if (miso != 8'h00)
                                begin
                                    done = 1'b1; st = sdc_pkg::ST_WRITE;
                                    phase_next = sdc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    mosi = 8'hFE; sel = 1'b1;
                                    phase_next = sdc_pkg::PH_WR_DATA; cnt_next = '0;
                                end
                            end
                            default: phase_next = sdc_pkg::PH_IDLE;
                        endcase
                    end
                end
                sdc_pkg::PH_EXTRA:
                begin
                    reg_we = 1'b1;
                    cnt_next = cnt_reg + 10'd1;
                    if (cnt_next < ((cidx == sdc_pkg::CMD13) ? 10'd2 : 10'd4))
                        sel = 1'b1;
                    else if (cidx == sdc_pkg::CMD8)
                    begin
                        // bytes 2 and 3: index 3 is this cycle's byte
                        if (regs_reg[2] == 8'h01 && miso == 8'hAA)
                        begin
                            if (acmd41_limit == 16'd0)
                            begin
                                done = 1'b1; st = sdc_pkg::ST_ACMD41;
                                phase_next = sdc_pkg::PH_IDLE; poll_next = '0;
                            end
                            else
                            begin
                                poll_next = 16'd1;
                                frame_next = sdc_pkg::make_frame(sdc_pkg::CMD55,
                                                                 32'd0, 8'h01);
                                phase_next = sdc_pkg::PH_NEXT_CMD;
                            end
                        end
                        else
                        begin
                            done = 1'b1; st = sdc_pkg::ST_VOLTAGE;
                            phase_next = sdc_pkg::PH_IDLE;
                        end
                    end
                    else if (cidx == sdc_pkg::CMD58)
                    begin
                        if (frame_reg[7:0] != 8'h00)
                        begin
                            done = 1'b1; st = sdc_pkg::ST_OCR;
                            phase_next = sdc_pkg::PH_IDLE;
                        end
                        else
                        begin
                            hc_next = regs_reg[0][6];
                            frame_next = sdc_pkg::make_frame(sdc_pkg::CMD9, 32'd0, 8'hAF);
                            phase_next = sdc_pkg::PH_NEXT_CMD;
                        end
                    end
                    else
                    begin
                        done = 1'b1; phase_next = sdc_pkg::PH_IDLE;
                        st = (frame_reg[7:0] != 8'h00) ? sdc_pkg::ST_WRITE : sdc_pkg::ST_OK;
                    end
                end
                sdc_pkg::PH_TOKEN:
                begin
                    if (miso == 8'hFE)
                    begin
                        sel = 1'b1; phase_next = sdc_pkg::PH_DATA; cnt_next = '0;
                    end
                    else if (poll_reg >= token_limit)
                    begin
                        done = 1'b1; st = sdc_pkg::ST_WAIT;
                        phase_next = sdc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        poll_next = poll_reg + 16'd1; sel = 1'b1;
                    end
                end
                sdc_pkg::PH_DATA:
                begin
                    cnt_next = cnt_reg + 10'd1;
                    if (cidx == sdc_pkg::CMD9)
                    begin
                        reg_we = (cnt_reg < 10'd16);
                        if (cnt_next < 10'd18)
                            sel = 1'b1;
                        else
                        begin
                            csd_load = 1'b1;
                            if (hc_reg)
                            begin
                                init_next = 1'b1; done = 1'b1;
                                phase_next = sdc_pkg::PH_IDLE;
                            end
                            else
                            begin
                                frame_next = sdc_pkg::make_frame(sdc_pkg::CMD16,
                                                    32'(sdc_pkg::BLOCK_BYTES), 8'hFF);
                                phase_next = sdc_pkg::PH_NEXT_CMD;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg < 10'(sdc_pkg::BLOCK_BYTES))
                        begin
                            rd = miso; rdv = 1'b1;
                        end
                        if (cnt_reg < 10'(sdc_pkg::BLOCK_BYTES + 1))
                            sel = 1'b1;
                        else
                        begin
                            done = 1'b1; phase_next = sdc_pkg::PH_IDLE;
                        end
                    end
                end
                sdc_pkg::PH_WR_DATA:
                begin
                    if (cnt_reg < 10'(sdc_pkg::BLOCK_BYTES))
                    begin
                        taken = 1'b1; cnt_next = cnt_reg + 10'd1;
                        mosi = item.write_data_byte; sel = 1'b1;
                    end
                    else if (cnt_reg < 10'(sdc_pkg::BLOCK_BYTES + 3))
                    begin
                        cnt_next = cnt_reg + 10'd1; sel = 1'b1;
                    end
                    else if (miso[4:0] != 5'h05)
                    begin
                        done = 1'b1; st = sdc_pkg::ST_WRITE;
                        phase_next = sdc_pkg::PH_IDLE;
                    end
                    else if (busy_limit == 16'd0)
                    begin
                        done = 1'b1; st = sdc_pkg::ST_WAIT;
                        phase_next = sdc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        sel = 1'b1; phase_next = sdc_pkg::PH_BUSY; poll_next = 16'd1;
                    end
                end
                sdc_pkg::PH_BUSY:
                begin
                    if (miso != 8'h00)
                    begin
                        frame_next = sdc_pkg::make_frame(sdc_pkg::CMD13, 32'd0, 8'h01);
                        phase_next = sdc_pkg::PH_NEXT_CMD;
                    end
                    else if (poll_reg >= busy_limit)
                    begin
                        done = 1'b1; st = sdc_pkg::ST_WAIT;
                        phase_next = sdc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        poll_next = poll_reg + 16'd1; sel = 1'b1;
                    end
                end
                default: phase_next = sdc_pkg::PH_IDLE;
            endcase
        end
        if (!done)
            st = sdc_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sdc_pkg::PH_IDLE;
            cnt_reg   <= '0;
            poll_reg  <= '0;
            frame_reg <= '0;
            hc_reg    <= 1'b0;
            init_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            poll_reg  <= poll_next;
            frame_reg <= frame_next;
            hc_reg    <= hc_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && reg_we)
            regs_reg[reg_wa] <= miso;
    end

    always_comb
    begin
        result.mosi_byte        = mosi;
        result.select_card      = sel;
        result.read_byte        = rd;
        result.read_byte_valid  = rdv;
        result.write_byte_taken = taken;
        result.done_res         = done;
        result.status           = st;
        result.high_capacity    = hc_next;
        result.card_blocks      = blocks;
        result.card_ready       = init_next;
    end
endmodule

// ===== rtl/sd_card_spi_mode_controller_top.sv =====
// channel   dir  payload
// in_ch     in   opcode, block_address, miso_byte, write_data_byte
// out_ch    out  mosi_byte .. card_ready, one result per item
// cfg       in   cfg_we / cfg_index / cfg_data, three 16-bit limits
// one item per cycle while out_ch is not stalled: the fsm step is combinational into the result register
// card_blocks is computed in the decoder register and is fed from there
// rst_n clears fsm state and flags and sets the limits to (1000, 2000, 300)
// input ready while the result register is empty or being drained
module sd_card_spi_mode_controller_top #(
    parameter int RESPONSE_POLLS = 10,
    parameter int POWERUP_BYTES  = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    sdc_in_if.sink      in_ch,
    sdc_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] acmd_reg, token_reg, busy_reg;
    logic        out_valid_reg;
    sdc_pkg::out_item_t out_reg;
    sdc_pkg::out_item_t res;
    logic        step;
    logic        done_q_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;

    sdc_core #(
        .RESPONSE_POLLS (RESPONSE_POLLS),
        .POWERUP_BYTES  (POWERUP_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_ch.payload),
        .acmd41_limit (acmd_reg),
        .token_limit  (token_reg),
        .busy_limit   (busy_reg),
        .result       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acmd_reg  <= 16'd1000;
            token_reg <= 16'd2000;
            busy_reg  <= 16'd300;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdc_pkg::CFG_ACMD41: acmd_reg  <= cfg_data;
                sdc_pkg::CFG_TOKEN:  token_reg <= cfg_data;
                sdc_pkg::CFG_BUSY:   busy_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_q_reg    <= 1'b0;
        end
        else
        begin
            done_q_reg <= step;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    // the capacity decoder updates on the same edge as the result register
    always_comb
    begin
        out_ch.payload = out_reg;
        out_ch.payload.card_blocks = res.card_blocks;
        if (!done_q_reg && !out_valid_reg)
            out_ch.payload.card_blocks = out_reg.card_blocks;
    end

    assign out_ch.valid = out_valid_reg;
endmodule
